[rtl/core/mebt_pkg.sv]
// ----------------------------------------------------------------------------
// mebt_pkg - shared types and constants for the escape-time pixel engine
// Fixed-point format, register indexes, sequencer states and saturating
// arithmetic helpers used across the engine.
// ----------------------------------------------------------------------------
package mebt_pkg;

  // Number format: signed two's complement, FRACTION_BITS fraction bits
  localparam int FRACTION_BITS  = 60;
  localparam int COORD_W        = 64;
  localparam int PROD_W         = 2 * COORD_W;
  localparam int HALF_W         = COORD_W / 2;
  localparam int COUNT_BITS     = 16;
  localparam int IDX_W          = 12;
  localparam int PIX_W          = 13;
  localparam int MAX_RESOLUTION = 4096;
  localparam int CFG_IDX_W      = 3;

  localparam logic [COORD_W-1:0] SIGN_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [COORD_W-1:0] SIGN_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] ONE_FX   = {{(COORD_W-1){1'b0}}, 1'b1} << FRACTION_BITS;
  localparam logic [COORD_W-1:0] NEG_ONE  = ~ONE_FX + {{(COORD_W-1){1'b0}}, 1'b1};
  localparam logic [COORD_W-1:0] HALF_FX    = ONE_FX >> 1;
  localparam logic [COORD_W-1:0] QUARTER_FX = ONE_FX >> 2;
  localparam logic [COORD_W-1:0] FOUR_FX    = ONE_FX << 2;

  // Reset view: real [-2, 1], imaginary [-1.5, 1.5]
  localparam logic [COORD_W-1:0] REAL_LOW_RST  = ~(ONE_FX << 1) + {{(COORD_W-1){1'b0}}, 1'b1};
  localparam logic [COORD_W-1:0] REAL_HIGH_RST = ONE_FX;
  localparam logic [COORD_W-1:0] IMAG_HIGH_RST =
    {{(COORD_W-2){1'b0}}, 2'b11} << (FRACTION_BITS - 1);
  localparam logic [COORD_W-1:0] IMAG_LOW_RST  =
    ~IMAG_HIGH_RST + {{(COORD_W-1){1'b0}}, 1'b1};
  localparam logic [PIX_W-1:0]      PIX_RST   = PIX_W'(1024);
  localparam logic [COUNT_BITS-1:0] LIMIT_RST = COUNT_BITS'(256);
  localparam logic [PIX_W-1:0]      MAX_RES   = PIX_W'(MAX_RESOLUTION);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REAL_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REAL_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAG_LOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAG_HIGH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT      = 3'd6;

  // Right shift applied to a product
  typedef enum logic [1:0] {
    SH_NONE,
    SH_FRAC,
    SH_FRAC_M1
  } mul_shift_t;

  typedef enum logic [3:0] {
    ST_DIV_RE,
    ST_DIV_IM,
    ST_IDLE,
    ST_CX,
    ST_CY,
    ST_CHK,
    ST_CXX,
    ST_CYY,
    ST_CQ,
    ST_XX,
    ST_YY,
    ST_XY,
    ST_DONE
  } mebt_state_t;

  function automatic logic s_lt(input logic [COORD_W-1:0] a, input logic [COORD_W-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic logic [COORD_W-1:0] magn(input logic [COORD_W-1:0] a);
    return a[COORD_W-1] ? (~a + {{(COORD_W-1){1'b0}}, 1'b1}) : a;
  endfunction

  function automatic logic [COORD_W-1:0] sat_add(input logic [COORD_W-1:0] a,
                                                 input logic [COORD_W-1:0] b);
    logic [COORD_W-1:0] r;
    r = a + b;
    if (a[COORD_W-1] == b[COORD_W-1] && r[COORD_W-1] != a[COORD_W-1])
      r = a[COORD_W-1] ? SIGN_MIN : SIGN_MAX;
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] sat_sub(input logic [COORD_W-1:0] a,
                                                 input logic [COORD_W-1:0] b);
    logic [COORD_W-1:0] r;
    r = a - b;
    if (a[COORD_W-1] != b[COORD_W-1] && r[COORD_W-1] != a[COORD_W-1])
      r = a[COORD_W-1] ? SIGN_MIN : SIGN_MAX;
    return r;
  endfunction

endpackage

[rtl/core/mebt_mul.sv]
// ----------------------------------------------------------------------------
// mebt_mul - shared multi-cycle fixed-point multiplier
// Exact signed 64x64 product from four 32x32 partial products, arithmetic
// right shift and saturation to 64 bits.
// ----------------------------------------------------------------------------
module mebt_mul (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [mebt_pkg::COORD_W-1:0]      op_a,
  input  logic [mebt_pkg::COORD_W-1:0]      op_b,
  input  mebt_pkg::mul_shift_t              shift,
  output logic                              done,
  output logic [mebt_pkg::COORD_W-1:0]      product
);

  localparam int CW = mebt_pkg::COORD_W;
  localparam int PW = mebt_pkg::PROD_W;
  localparam int HW = mebt_pkg::HALF_W;
  localparam int FB = mebt_pkg::FRACTION_BITS;
  localparam logic [2:0] STEP_SHIFT = 3'd4;
  localparam logic [2:0] STEP_ROUND = 3'd5;

  logic                  run_r;
  logic                  done_r;
  logic [2:0]            step_r;
  logic [CW-1:0]         ma_r;
  logic [CW-1:0]         mb_r;
  logic                  neg_r;
  mebt_pkg::mul_shift_t  shift_r;
  logic [PW-1:0]         acc_r;
  logic                  hi_nz_r;
  logic [CW-1:0]         low_r;
  logic                  lost_r;
  logic [CW-1:0]         product_r;

  logic [HW-1:0]         half_a;
  logic [HW-1:0]         half_b;
  logic [CW-1:0]         pp;
  logic [PW-1:0]         pp_aligned;
  logic [PW-1:0]         shifted;
  logic                  lost;
  logic [CW:0]           mag_round;
  logic [CW-1:0]         result;

  // Partial product select: lo*lo, lo*hi, hi*lo, hi*hi
  always_comb begin
    half_a     = step_r[1] ? ma_r[CW-1:HW] : ma_r[HW-1:0];
    half_b     = step_r[0] ? mb_r[CW-1:HW] : mb_r[HW-1:0];
    pp         = {{HW{1'b0}}, half_a} * {{HW{1'b0}}, half_b};
    case (step_r[1:0])
      2'd0:    pp_aligned = {{CW{1'b0}}, pp};
      2'd3:    pp_aligned = {pp, {CW{1'b0}}};
      default: pp_aligned = {{HW{1'b0}}, pp, {HW{1'b0}}};
    endcase
  end

  // Shift of the magnitude; bits shifted out round a negative result down
  always_comb begin
    case (shift_r)
      mebt_pkg::SH_FRAC: begin
        shifted = acc_r >> FB;
        lost    = |acc_r[FB-1:0];
      end
      mebt_pkg::SH_FRAC_M1: begin
        shifted = acc_r >> (FB - 1);
        lost    = |acc_r[FB-2:0];
      end
      default: begin
        shifted = acc_r;
        lost    = 1'b0;
      end
    endcase
  end

  always_comb begin
    mag_round = {1'b0, low_r} + {{CW{1'b0}}, lost_r};
    if (neg_r) begin
      if (hi_nz_r || mag_round[CW] || (mag_round[CW-1] && (|mag_round[CW-2:0])))
        result = mebt_pkg::SIGN_MIN;
      else
        result = ~mag_round[CW-1:0] + {{(CW-1){1'b0}}, 1'b1};
    end else begin
      if (hi_nz_r || mag_round[CW] || mag_round[CW-1])
        result = mebt_pkg::SIGN_MAX;
      else
        result = mag_round[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= 3'd0;
      end else if (run_r) begin
        step_r <= step_r + 3'd1;
        if (step_r == STEP_ROUND) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma_r    <= mebt_pkg::magn(op_a);
      mb_r    <= mebt_pkg::magn(op_b);
      neg_r   <= op_a[CW-1] ^ op_b[CW-1];
      shift_r <= shift;
      acc_r   <= '0;
    end else if (run_r) begin
      if (step_r < STEP_SHIFT) begin
        acc_r <= acc_r + pp_aligned;
      end else if (step_r == STEP_SHIFT) begin
        hi_nz_r <= |shifted[PW-1:CW];
        low_r   <= shifted[CW-1:0];
        lost_r  <= lost & neg_r;
      end else begin
        product_r <= result;
      end
    end
  end

  assign done    = done_r;
  assign product = product_r;

endmodule

[rtl/core/mebt_div.sv]
// ----------------------------------------------------------------------------
// mebt_div - restoring divider for the pixel step
// Unsigned 64-bit dividend by a 13-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mebt_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [mebt_pkg::COORD_W-1:0]   dividend,
  input  logic [mebt_pkg::PIX_W-1:0]     divisor,
  output logic                           done,
  output logic [mebt_pkg::COORD_W-1:0]   quotient
);

  localparam int CW = mebt_pkg::COORD_W;
  localparam int DW = mebt_pkg::PIX_W;
  localparam int NW = $clog2(CW);
  localparam logic [NW-1:0] LAST = NW'(CW - 1);

  logic          run_r;
  logic          done_r;
  logic [NW-1:0] cnt_r;
  logic [CW-1:0] quo_r;
  logic [DW-2:0] rem_r;
  logic [DW-1:0] den_r;

  logic [DW-1:0] trial;
  logic          fits;
  logic [DW-1:0] diff;

  // Remainder stays below the divisor, so it fits one bit narrower
  always_comb begin
    trial = {rem_r, quo_r[CW-1]};
    fits  = trial >= den_r;
    diff  = trial - den_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + {{(NW-1){1'b0}}, 1'b1};
        if (cnt_r == LAST) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (run_r) begin
      quo_r <= {quo_r[CW-2:0], fits};
      rem_r <= fits ? diff[DW-2:0] : trial[DW-2:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[rtl/core/mandelbrot_escape_time_pixel.sv]
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel - escape-time count for one pixel
// Maps a pixel column and line onto the complex plane, tries the main
// cardioid shortcut, then iterates z = z^2 + c on one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_column/in_line and raise start; the beat is taken at an
//   edge where start is high and busy is low. busy stays high until the
//   result has been shown.
//   Output: out_valid pulses for one cycle with out_escape_count; there is no
//   back-pressure, so capture the beat in that cycle.
//   Config: cfg_valid/cfg_ready write channel, cfg_index selects the register
//   (0 real_low .. 6 iteration_limit), unknown indexes are dropped. Each write
//   recomputes both pixel steps on the shared divider with busy high. The same
//   recompute runs right after reset.
// Sequence:
//   Every product goes through the single 32x32-based multiplier. Point
//   mapping takes two products and the cardioid test three more when the
//   point is near; each z iteration takes three products, and the escaping
//   one stops after its two squares. The next beat is taken the cycle after
//   the result.
// Reset: synchronous, active low; restores the default view [-2,1]x[-1.5,1.5],
//   1024x1024 pixels and a limit of 256.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input beat
  input  logic                                 start,
  output logic                                 busy,
  input  logic [mebt_pkg::IDX_W-1:0]           in_column,
  input  logic [mebt_pkg::IDX_W-1:0]           in_line,
  // result beat
  output logic                                 out_valid,
  output logic [mebt_pkg::COUNT_BITS-1:0]      out_escape_count,
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mebt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mebt_pkg::COORD_W-1:0]         cfg_data
);

  localparam int CW = mebt_pkg::COORD_W;
  localparam int PW = mebt_pkg::PIX_W;
  localparam int NB = mebt_pkg::COUNT_BITS;
  localparam int IW = mebt_pkg::IDX_W;

  mebt_pkg::mebt_state_t state_r, state_nxt;

  // configuration
  logic [CW-1:0] real_low_r, real_high_r, imag_low_r, imag_high_r;
  logic [PW-1:0] width_r, height_r;
  logic [NB-1:0] limit_r;
  logic [CW-1:0] real_step_r, imag_step_r;

  // pixel datapath
  logic [IW-1:0] col_r, line_r;
  logic [CW-1:0] cx_r, cy_r, x_r, q_r, xx_r, yy_r, zx_r, zy_r;
  logic [NB-1:0] n_r;
  logic          pend_r;

  // shared units
  logic                  mul_start, mul_done;
  logic [CW-1:0]         mul_a, mul_b, mul_res;
  mebt_pkg::mul_shift_t  mul_sh;
  logic                  div_start, div_done;
  logic [CW-1:0]         div_mag, div_quo, step_sat;
  logic [PW-1:0]         div_cnt, div_den;
  logic [CW-1:0]         div_low, div_high;
  logic                  div_neg;

  logic in_take, cfg_take, cfg_known;
  logic far, cardioid_hit, escaped, more;

  assign in_take  = start && !busy;
  assign cfg_take = cfg_valid && cfg_ready;

  always_comb begin
    case (cfg_index)
      mebt_pkg::CFG_REAL_LOW, mebt_pkg::CFG_REAL_HIGH, mebt_pkg::CFG_IMAG_LOW,
      mebt_pkg::CFG_IMAG_HIGH, mebt_pkg::CFG_WIDTH, mebt_pkg::CFG_HEIGHT,
      mebt_pkg::CFG_LIMIT: cfg_known = 1'b1;
      default:             cfg_known = 1'b0;
    endcase
  end

  // Step divider operands: span magnitude and clamped pixel count
  always_comb begin
    if (state_r == mebt_pkg::ST_DIV_IM) begin
      div_low  = imag_low_r;
      div_high = imag_high_r;
      div_cnt  = height_r;
    end else begin
      div_low  = real_low_r;
      div_high = real_high_r;
      div_cnt  = width_r;
    end
    div_neg = mebt_pkg::s_lt(div_high, div_low);
    div_mag = div_neg ? (div_low - div_high) : (div_high - div_low);
    if (div_cnt == '0)
      div_den = {{(PW-1){1'b0}}, 1'b1};
    else if (div_cnt > mebt_pkg::MAX_RES)
      div_den = mebt_pkg::MAX_RES;
    else
      div_den = div_cnt;
    if (!div_neg)
      step_sat = div_quo[CW-1] ? mebt_pkg::SIGN_MAX : div_quo;
    else if (div_quo > mebt_pkg::SIGN_MIN)
      step_sat = mebt_pkg::SIGN_MIN;
    else
      step_sat = ~div_quo + {{(CW-1){1'b0}}, 1'b1};
  end

  // Decision terms
  always_comb begin
    far = mebt_pkg::s_lt(cx_r, mebt_pkg::NEG_ONE) || mebt_pkg::s_lt(mebt_pkg::HALF_FX, cx_r) ||
          mebt_pkg::s_lt(cy_r, mebt_pkg::NEG_ONE) || mebt_pkg::s_lt(mebt_pkg::ONE_FX, cy_r);
    cardioid_hit = mebt_pkg::s_lt(mul_res, {2'b00, yy_r[CW-1:2]});
    escaped      = !mebt_pkg::s_lt(mebt_pkg::sat_add(xx_r, mul_res), mebt_pkg::FOUR_FX);
    more         = n_r < limit_r;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mebt_pkg::ST_DIV_RE: if (div_done) state_nxt = mebt_pkg::ST_DIV_IM;
      mebt_pkg::ST_DIV_IM: if (div_done) state_nxt = mebt_pkg::ST_IDLE;
      mebt_pkg::ST_IDLE: begin
        if (in_take)
          state_nxt = mebt_pkg::ST_CX;
        else if (cfg_take && cfg_known)
          state_nxt = mebt_pkg::ST_DIV_RE;
      end
      mebt_pkg::ST_CX:  if (mul_done) state_nxt = mebt_pkg::ST_CY;
      mebt_pkg::ST_CY:  if (mul_done) state_nxt = mebt_pkg::ST_CHK;
      mebt_pkg::ST_CHK: state_nxt = far ? mebt_pkg::ST_XX : mebt_pkg::ST_CXX;
      mebt_pkg::ST_CXX: if (mul_done) state_nxt = mebt_pkg::ST_CYY;
      mebt_pkg::ST_CYY: if (mul_done) state_nxt = mebt_pkg::ST_CQ;
      mebt_pkg::ST_CQ: begin
        if (mul_done) state_nxt = cardioid_hit ? mebt_pkg::ST_DONE : mebt_pkg::ST_XX;
      end
      mebt_pkg::ST_XX: begin
        if (!more && !pend_r)
          state_nxt = mebt_pkg::ST_DONE;
        else if (mul_done)
          state_nxt = mebt_pkg::ST_YY;
      end
      mebt_pkg::ST_YY: begin
        if (mul_done) state_nxt = escaped ? mebt_pkg::ST_DONE : mebt_pkg::ST_XY;
      end
      mebt_pkg::ST_XY:   if (mul_done) state_nxt = mebt_pkg::ST_XX;
      mebt_pkg::ST_DONE: state_nxt = mebt_pkg::ST_IDLE;
      default:           state_nxt = mebt_pkg::ST_IDLE;
    endcase
  end

  // Outputs and unit requests
  always_comb begin
    busy      = 1'b1;
    out_valid = 1'b0;
    cfg_ready = 1'b0;
    div_start = 1'b0;
    mul_start = 1'b0;
    mul_a     = zx_r;
    mul_b     = zx_r;
    mul_sh    = mebt_pkg::SH_FRAC;
    case (state_r)
      mebt_pkg::ST_IDLE: begin
        busy      = 1'b0;
        cfg_ready = !start;
      end
      mebt_pkg::ST_DIV_RE, mebt_pkg::ST_DIV_IM: div_start = !pend_r;
      mebt_pkg::ST_CX: begin
        mul_start = !pend_r;
        mul_a     = real_step_r;
        mul_b     = {{(CW-IW){1'b0}}, col_r};
        mul_sh    = mebt_pkg::SH_NONE;
      end
      mebt_pkg::ST_CY: begin
        mul_start = !pend_r;
        mul_a     = imag_step_r;
        mul_b     = {{(CW-IW){1'b0}}, line_r};
        mul_sh    = mebt_pkg::SH_NONE;
      end
      mebt_pkg::ST_CXX: begin
        mul_start = !pend_r;
        mul_a     = x_r;
        mul_b     = x_r;
      end
      mebt_pkg::ST_CYY: begin
        mul_start = !pend_r;
        mul_a     = cy_r;
        mul_b     = cy_r;
      end
      mebt_pkg::ST_CQ: begin
        mul_start = !pend_r;
        mul_a     = q_r;
        mul_b     = mebt_pkg::sat_add(q_r, x_r);
      end
      mebt_pkg::ST_XX: mul_start = !pend_r && more;
      mebt_pkg::ST_YY: begin
        mul_start = !pend_r;
        mul_a     = zy_r;
        mul_b     = zy_r;
      end
      mebt_pkg::ST_XY: begin
        mul_start = !pend_r;
        mul_a     = zx_r;
        mul_b     = zy_r;
        mul_sh    = mebt_pkg::SH_FRAC_M1;
      end
      mebt_pkg::ST_DONE: out_valid = 1'b1;
      default: ;
    endcase
  end

  assign out_escape_count = n_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mebt_pkg::ST_DIV_RE;
      pend_r      <= 1'b0;
      real_low_r  <= mebt_pkg::REAL_LOW_RST;
      real_high_r <= mebt_pkg::REAL_HIGH_RST;
      imag_low_r  <= mebt_pkg::IMAG_LOW_RST;
      imag_high_r <= mebt_pkg::IMAG_HIGH_RST;
      width_r     <= mebt_pkg::PIX_RST;
      height_r    <= mebt_pkg::PIX_RST;
      limit_r     <= mebt_pkg::LIMIT_RST;
    end else begin
      state_r <= state_nxt;
      // hold the request flag until the unit answers
      if (mul_start || div_start)
        pend_r <= 1'b1;
      else if (mul_done || div_done)
        pend_r <= 1'b0;
      if (cfg_take) begin
        case (cfg_index)
          mebt_pkg::CFG_REAL_LOW:  real_low_r  <= cfg_data;
          mebt_pkg::CFG_REAL_HIGH: real_high_r <= cfg_data;
          mebt_pkg::CFG_IMAG_LOW:  imag_low_r  <= cfg_data;
          mebt_pkg::CFG_IMAG_HIGH: imag_high_r <= cfg_data;
          mebt_pkg::CFG_WIDTH:     width_r     <= cfg_data[PW-1:0];
          mebt_pkg::CFG_HEIGHT:    height_r    <= cfg_data[PW-1:0];
          mebt_pkg::CFG_LIMIT:     limit_r     <= cfg_data[NB-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath: capture each unit answer according to the step in progress
  always_ff @(posedge clk) begin
    case (state_r)
      mebt_pkg::ST_DIV_RE: if (div_done) real_step_r <= step_sat;
      mebt_pkg::ST_DIV_IM: if (div_done) imag_step_r <= step_sat;
      mebt_pkg::ST_IDLE: begin
        if (in_take) begin
          col_r  <= in_column;
          line_r <= in_line;
        end
      end
      mebt_pkg::ST_CX: if (mul_done) cx_r <= mebt_pkg::sat_add(real_low_r, mul_res);
      mebt_pkg::ST_CY: if (mul_done) cy_r <= mebt_pkg::sat_add(imag_low_r, mul_res);
      mebt_pkg::ST_CHK: begin
        x_r  <= mebt_pkg::sat_sub(cx_r, mebt_pkg::QUARTER_FX);
        zx_r <= '0;
        zy_r <= '0;
        n_r  <= '0;
      end
      mebt_pkg::ST_CXX: if (mul_done) xx_r <= mul_res;
      mebt_pkg::ST_CYY: begin
        if (mul_done) begin
          yy_r <= mul_res;
          q_r  <= mebt_pkg::sat_add(xx_r, mul_res);
        end
      end
      mebt_pkg::ST_CQ: if (mul_done && cardioid_hit) n_r <= limit_r;
      mebt_pkg::ST_XX: if (mul_done) xx_r <= mul_res;
      mebt_pkg::ST_YY: if (mul_done) yy_r <= mul_res;
      mebt_pkg::ST_XY: begin
        if (mul_done) begin
          zy_r <= mebt_pkg::sat_add(mul_res, cy_r);
          zx_r <= mebt_pkg::sat_add(mebt_pkg::sat_sub(xx_r, yy_r), cx_r);
          n_r  <= n_r + {{(NB-1){1'b0}}, 1'b1};
        end
      end
      default: ;
    endcase
  end

  mebt_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .shift   (mul_sh),
    .done    (mul_done),
    .product (mul_res)
  );

  mebt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_mag),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_quo)
  );

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench - escape-time pixel engine check
// Drives pixel beats in random bursts across many views and iteration limits,
// predicts each escape count with an independent fixed-point model of the
// mapping, the cardioid shortcut and the z iteration, and checks every result
// beat in order.
// ----------------------------------------------------------------------------

typedef logic [63:0] fx_t;

typedef struct {
  logic [11:0] col;
  logic [11:0] row;
  logic [15:0] count;
} pixel_expect_t;

class escape_scoreboard;
  localparam int  FRAC       = 60;
  localparam fx_t FX_MIN     = 64'h8000_0000_0000_0000;
  localparam fx_t FX_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam fx_t FX_ONE     = 64'h1000_0000_0000_0000;
  localparam fx_t FX_NEG_ONE = 64'hF000_0000_0000_0000;
  localparam fx_t FX_HALF    = 64'h0800_0000_0000_0000;
  localparam fx_t FX_QUARTER = 64'h0400_0000_0000_0000;
  localparam fx_t FX_FOUR    = 64'h4000_0000_0000_0000;

  fx_t           re_lo, re_hi, im_lo, im_hi, re_step, im_step;
  logic [12:0]   cols, rows;
  logic [15:0]   iter_max;
  pixel_expect_t pending_counts[$];
  int            mismatches;

  function new();
    re_lo      = 64'hE000_0000_0000_0000;
    re_hi      = FX_ONE;
    im_lo      = 64'hE800_0000_0000_0000;
    im_hi      = 64'h1800_0000_0000_0000;
    cols       = 13'd1024;
    rows       = 13'd1024;
    iter_max   = 16'd256;
    mismatches = 0;
    update_steps();
  endfunction

  function fx_t sat_sum(fx_t a, fx_t b);
    fx_t r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) r = a[63] ? FX_MIN : FX_MAX;
    return r;
  endfunction

  function fx_t sat_diff(fx_t a, fx_t b);
    fx_t r;
    r = a - b;
    if (a[63] != b[63] && r[63] != a[63]) r = a[63] ? FX_MIN : FX_MAX;
    return r;
  endfunction

  // exact 128-bit product, arithmetic shift, clamp to 64 bits
  function fx_t fx_product(fx_t a, fx_t b, int unsigned sh);
    logic signed [127:0] wide;
    wide = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
    wide = wide >>> sh;
    if (wide[127:63] == '0 || wide[127:63] == '1) return wide[63:0];
    return wide[127] ? FX_MIN : FX_MAX;
  endfunction

  function fx_t pixel_step(fx_t lo, fx_t hi, logic [12:0] count);
    logic [63:0] d, mag, q;
    bit          neg;
    d = (count == 13'd0) ? 64'd1 : {51'd0, count};
    if (d > 64'(mebt_pkg::MAX_RESOLUTION)) d = 64'(mebt_pkg::MAX_RESOLUTION);
    neg = $signed(hi) < $signed(lo);
    mag = neg ? lo - hi : hi - lo;
    q   = mag / d;
    if (!neg) return (q > FX_MAX) ? FX_MAX : q;
    return (q > FX_MIN) ? FX_MIN : -q;
  endfunction

  function void update_steps();
    re_step = pixel_step(re_lo, re_hi, cols);
    im_step = pixel_step(im_lo, im_hi, rows);
  endfunction

  function bit in_main_cardioid(fx_t cx, fx_t cy);
    fx_t x, yy, q, lhs, rhs;
    if ($signed(cx) < $signed(FX_NEG_ONE) || $signed(FX_HALF) < $signed(cx)) return 1'b0;
    if ($signed(cy) < $signed(FX_NEG_ONE) || $signed(FX_ONE) < $signed(cy)) return 1'b0;
    x   = sat_diff(cx, FX_QUARTER);
    yy  = fx_product(cy, cy, FRAC);
    q   = sat_sum(fx_product(x, x, FRAC), yy);
    lhs = fx_product(q, sat_sum(q, x), FRAC);
    rhs = fx_product(FX_QUARTER, yy, FRAC);
    return $signed(lhs) < $signed(rhs);
  endfunction

  function logic [15:0] escape_iterations(logic [11:0] col, logic [11:0] row);
    fx_t         cx, cy, zx, zy, xx, yy, nx;
    int unsigned n;
    cx = sat_sum(re_lo, fx_product(re_step, {52'd0, col}, 0));
    cy = sat_sum(im_lo, fx_product(im_step, {52'd0, row}, 0));
    zx = '0;
    zy = '0;
    n  = 0;
    if (in_main_cardioid(cx, cy)) n = iter_max;
    while (n < iter_max) begin
      xx = fx_product(zx, zx, FRAC);
      yy = fx_product(zy, zy, FRAC);
      if (!($signed(sat_sum(xx, yy)) < $signed(FX_FOUR))) break;
      nx = sat_sum(sat_diff(xx, yy), cx);
      zy = sat_sum(fx_product(zx, zy, FRAC - 1), cy);
      zx = nx;
      n++;
    end
    return n[15:0];
  endfunction

  function void write_reg(logic [2:0] idx, logic [63:0] data);
    case (idx)
      mebt_pkg::CFG_REAL_LOW:  re_lo = data;
      mebt_pkg::CFG_REAL_HIGH: re_hi = data;
      mebt_pkg::CFG_IMAG_LOW:  im_lo = data;
      mebt_pkg::CFG_IMAG_HIGH: im_hi = data;
      mebt_pkg::CFG_WIDTH:     cols = data[12:0];
      mebt_pkg::CFG_HEIGHT:    rows = data[12:0];
      mebt_pkg::CFG_LIMIT:     iter_max = data[15:0];
      default:                 return;
    endcase
    update_steps();
  endfunction

  function void note_pixel(logic [11:0] col, logic [11:0] row);
    pixel_expect_t e;
    e.col   = col;
    e.row   = row;
    e.count = escape_iterations(col, row);
    pending_counts.push_back(e);
  endfunction

  function void check_count(logic [15:0] actual);
    pixel_expect_t e;
    if (pending_counts.size() == 0) begin
      if (mismatches < 10) $display("unexpected result beat: escape_count %0d", actual);
      mismatches++;
      return;
    end
    e = pending_counts.pop_front();
    if (actual !== e.count) begin
      if (mismatches < 10)
        $display("escape_count mismatch at column %0d line %0d: expected %0d, got %0d",
                 e.col, e.row, e.count, actual);
      mismatches++;
    end
  endfunction

  function int pending();
    return pending_counts.size();
  endfunction
endclass

module testbench;
  // Fixed-point values used by the directed views
  localparam fx_t FX_MIN       = 64'h8000_0000_0000_0000;
  localparam fx_t FX_MAX       = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam fx_t FX_ONE       = 64'h1000_0000_0000_0000;
  localparam fx_t FX_SEVEN     = 64'h7000_0000_0000_0000;
  localparam fx_t FX_NEG_SEVEN = 64'h9000_0000_0000_0000;
  localparam fx_t RE_LO_DEF    = 64'hE000_0000_0000_0000;
  localparam fx_t IM_LO_DEF    = 64'hE800_0000_0000_0000;
  localparam fx_t IM_HI_DEF    = 64'h1800_0000_0000_0000;
  localparam longint ONE_L     = 64'sh1000_0000_0000_0000;
  localparam longint MILLI     = ONE_L / 1000;
  // index with no register behind it; writes there must be dropped
  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS = 1300;

  logic clk = 1'b0;
  logic rst_n;
  logic start, busy;
  logic [mebt_pkg::IDX_W-1:0] in_column, in_line;
  logic out_valid;
  logic [mebt_pkg::COUNT_BITS-1:0] out_escape_count;
  logic cfg_valid, cfg_ready;
  logic [mebt_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mebt_pkg::COORD_W-1:0] cfg_data;

  escape_scoreboard board = new();

  // Watchdog allowance; every beat and register write adds its worst case
  longint unsigned cycle_budget = 200000;

  mandelbrot_escape_time_pixel DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_column        (in_column),
    .in_line          (in_line),
    .out_valid        (out_valid),
    .out_escape_count (out_escape_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  // Result side: there is no back-pressure, so take every strobed beat as it comes.
  // Sample at the edge that closes the cycle, before the block updates its outputs.
  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_count(out_escape_count);
  end

  // Watchdog: give up once the allowance runs out
  initial begin : watchdog
    longint unsigned waited;
    waited = 0;
    while (waited < cycle_budget) begin
      @(posedge clk);
      waited++;
    end
    $display("testbench: FAIL");
    $finish;
  end

  // Hold until every predicted count has come back
  task automatic wait_for_results();
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Present one pixel beat and hold it until busy is low at an edge.
  // Start is left high; the caller drops it when the burst ends.
  task automatic send_pixel(input logic [11:0] col, input logic [11:0] row);
    start     <= 1'b1;
    in_column <= col;
    in_line   <= row;
    cycle_budget += 100 * (longint'(board.iter_max) + 2) + 500;
    do @(posedge clk); while (busy);
    board.note_pixel(col, row);
  endtask

  // One register write beat; valid stays high so writes can go back to back
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    cycle_budget += 2000;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, data);
  endtask

  // Drain the engine, then rewrite the whole view. Optionally slip in a write
  // to the unused index first.
  task automatic set_view(input fx_t rl, input fx_t rh, input fx_t il, input fx_t ih,
                          input logic [63:0] w, input logic [63:0] h,
                          input logic [63:0] lim, input bit stray);
    wait_for_results();
    if (stray) write_reg(CFG_UNUSED, {$urandom, $urandom});
    write_reg(mebt_pkg::CFG_REAL_LOW, rl);
    write_reg(mebt_pkg::CFG_REAL_HIGH, rh);
    write_reg(mebt_pkg::CFG_IMAG_LOW, il);
    write_reg(mebt_pkg::CFG_IMAG_HIGH, ih);
    write_reg(mebt_pkg::CFG_WIDTH, w);
    write_reg(mebt_pkg::CFG_HEIGHT, h);
    write_reg(mebt_pkg::CFG_LIMIT, lim);
    cfg_valid <= 1'b0;
  endtask

  // One random phase: pick a view and a limit, then push pixels in bursts.
  // Most views sit around the set so points take real iterations; a few are
  // raw 64-bit noise with out-of-range counts and junk in the upper bits.
  task automatic random_phase(input int items);
    longint      c_re, c_im, h_re, h_im;
    fx_t         rl, rh, il, ih, tmp;
    logic [63:0] wv, hv, lim;
    int          w, h, sel, left, burst, gap;
    bit          wild;
    logic [11:0] col, row;
    wild = ($urandom_range(0, 9) == 0);
    sel  = $urandom_range(0, 19);
    if (sel == 0) lim = 64'd0;
    else if (sel < 17) lim = 64'($urandom_range(1, 40));
    else lim = 64'($urandom_range(41, 96));
    if (wild) begin
      rl  = {$urandom, $urandom};
      rh  = {$urandom, $urandom};
      il  = {$urandom, $urandom};
      ih  = {$urandom, $urandom};
      wv  = {$urandom, $urandom};
      hv  = {$urandom, $urandom};
      lim = ({$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_0000) | lim;
      w   = 4096;
      h   = 4096;
    end else begin
      c_re = -2 * ONE_L + longint'($urandom_range(0, 2500)) * MILLI;
      c_im = longint'($urandom_range(0, 2400)) * MILLI - 1200 * MILLI;
      h_re = (ONE_L >>> $urandom_range(1, 14)) * longint'($urandom_range(1, 4));
      h_im = (ONE_L >>> $urandom_range(1, 14)) * longint'($urandom_range(1, 4));
      rl = c_re - h_re;
      rh = c_re + h_re;
      il = c_im - h_im;
      ih = c_im + h_im;
      // reversed edges give negative steps
      if ($urandom_range(0, 7) == 0) begin
        tmp = rl;
        rl  = rh;
        rh  = tmp;
      end
      if ($urandom_range(0, 7) == 0) begin
        tmp = il;
        il  = ih;
        ih  = tmp;
      end
      w  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 64);
      h  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 64);
      wv = 64'(w);
      hv = 64'(h);
    end
    set_view(rl, rh, il, ih, wv, hv, lim, $urandom_range(0, 3) == 0);

    left = items;
    while (left > 0) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 48) : $urandom_range(1, 16);
      if (burst > left) burst = left;
      repeat (burst) begin
        // mostly inside the view; now and then anywhere in the index range
        if (wild || $urandom_range(0, 7) == 0) begin
          col = 12'($urandom);
          row = 12'($urandom);
        end else begin
          col = 12'($urandom_range(0, w - 1));
          row = 12'($urandom_range(0, h - 1));
        end
        send_pixel(col, row);
      end
      left -= burst;
      start <= 1'b0;
      // now and then let the engine run dry before the next burst
      if ($urandom_range(0, 7) == 0) wait_for_results();
      gap = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 60);
      cycle_budget += gap;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin : stimulus
    int sent;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_column <= '0;
    in_line   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Default view: a corner, a point near the origin and one at -0.5 (both in
    // the cardioid), a point in the period-two bulb that runs to the limit,
    // a far point and an index past the pixel count.
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd683, 12'd512);
    send_pixel(12'd512, 12'd512);
    send_pixel(12'd256, 12'd512);
    send_pixel(12'd1000, 12'd100);
    start <= 1'b0;

    // Zero limit: every count is zero, cardioid or not
    set_view(RE_LO_DEF, FX_ONE, IM_LO_DEF, IM_HI_DEF, 64'd1024, 64'd1024, 64'd0, 1'b0);
    send_pixel(12'd512, 12'd512);
    send_pixel(12'd0, 12'd0);
    start <= 1'b0;

    // Full limit on [0,1]^2: origin hits the cardioid, the rest escape fast
    set_view(64'd0, FX_ONE, 64'd0, FX_ONE, 64'd4096, 64'd4096, 64'd65535, 1'b0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd2048, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    start <= 1'b0;

    // Edges at the range ends with zero pixel counts: the steps overflow and clamp
    set_view(FX_MIN, FX_MAX, FX_MAX, FX_MIN, 64'd0, 64'd0, 64'd1, 1'b0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd1);
    send_pixel(12'd4095, 12'd4095);
    start <= 1'b0;

    // Oversized column count clamps; large indices drive the point into saturation
    set_view(FX_SEVEN, FX_MAX, FX_NEG_SEVEN, FX_MIN, 64'd8191, 64'd1, 64'd65535, 1'b0);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    start <= 1'b0;

    // Stray write to the unused index must leave the view alone
    set_view(RE_LO_DEF, FX_ONE, IM_LO_DEF, IM_HI_DEF, 64'd1024, 64'd1024, 64'd16, 1'b1);
    send_pixel(12'd300, 12'd700);
    send_pixel(12'd512, 12'd512);
    send_pixel(12'd4095, 12'd0);
    start <= 1'b0;

    // Random phases until the item count is reached
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      sel_len: begin
        int n;
        n = $urandom_range(20, 80);
        random_phase(n);
        sent += n;
      end
    end

    // Drain, then watch a little longer for stray result beats
    wait_for_results();
    cycle_budget += 10000;
    repeat (300) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule
